@@ src/tjdq_pkg.sv @@
// Package for the typed job dispatch queue.
// Holds field widths, operation and status codes, FSM states and the
// control structs shared by the queue cells, the completion FIFO and the top level.
package tjdq_pkg;

    localparam int TAG_W            = 8;
    localparam int JTYPE_W          = 8;
    localparam int OP_W             = 3;
    localparam int STATUS_W         = 3;
    localparam int DEF_QUEUE_DEPTH  = 16;
    localparam int DEF_SLOT_COUNT   = 8;
    localparam int DEF_DONE_DEPTH   = 16;

    typedef logic [TAG_W-1:0]   tag_t;
    typedef logic [JTYPE_W-1:0] jtype_t;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE    = 3'd0,
        OP_CLAIM      = 3'd1,
        OP_COMPLETE   = 3'd2,
        OP_RETRIEVE   = 3'd3,
        OP_CLEAR_PEND = 3'd4,
        OP_CLEAR_DONE = 3'd5
    } op_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE       = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_QUEUE_FULL = 3'd2,
        ST_NO_SLOT    = 3'd3,
        ST_DONE_FULL  = 3'd4
    } status_e;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_e;

    // Per-cell control of the pending queue
    typedef struct packed {
        logic capture;  // latch the match flag against the incoming claim mask
        logic load;     // write the new job into this cell
        logic shift;    // claim commits: cells at or behind the hit take their neighbor
    } cell_ctrl_t;

    // Completion FIFO control
    typedef struct packed {
        logic rd;       // register the head entry
        logic push;
        logic pop;
        logic clear;
    } fifo_ctrl_t;

endpackage

@@ src/tjdq_cell.sv @@
// One cell of the pending-job chain: holds a tag and type mask, flags a
// claim match and hands its contents to the left neighbor on compaction.
// Depends on tjdq_pkg.
module tjdq_cell
    import tjdq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       entry_valid,
    input  tag_t       new_tag,
    input  jtype_t     new_jtype,
    input  jtype_t     claim_mask,
    input  tag_t       nbr_tag,
    input  jtype_t     nbr_jtype,
    input  logic       hit_in,
    output logic       hit_out,
    output tag_t       tag_out,
    output jtype_t     jtype_out,
    output tag_t       sel_tag
);

    tag_t   tag_reg;
    jtype_t jtype_reg;
    logic   match_reg;
    logic   first_hit;
    logic   take_nbr;

    assign hit_out   = hit_in | match_reg;
    assign first_hit = match_reg & ~hit_in;
    assign take_nbr  = ctrl.shift & hit_out;
    assign sel_tag   = first_hit ? tag_reg : '0;
    assign tag_out   = tag_reg;
    assign jtype_out = jtype_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            tag_reg   <= new_tag;
            jtype_reg <= new_jtype;
        end
        else if (take_nbr)
        begin
            tag_reg   <= nbr_tag;
            jtype_reg <= nbr_jtype;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.capture)
        begin
            match_reg <= entry_valid & (|(jtype_reg & claim_mask));
        end
    end

endmodule

@@ src/tjdq_done_fifo.sv @@
// Completion FIFO: circular tag store with head pointer and fill count,
// registered read of the head entry. Depends on tjdq_pkg.
module tjdq_done_fifo
    import tjdq_pkg::*;
#(
    parameter int DEPTH = DEF_DONE_DEPTH,
    localparam int HW   = $clog2(DEPTH),
    localparam int FW   = $clog2(DEPTH + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  fifo_ctrl_t    ctrl,
    input  tag_t          wr_tag,
    output tag_t          rd_tag,
    output logic [FW-1:0] fill
);

    tag_t            mem [DEPTH];
    tag_t            rd_tag_reg;
    logic [HW-1:0]   head_reg;
    logic [FW-1:0]   fill_reg;
    logic [FW:0]     wr_sum;
    logic [HW-1:0]   wr_addr;

    // Tail = head + fill, wrapped once
    assign wr_sum  = (FW + 1)'(head_reg) + (FW + 1)'(fill_reg);
    assign wr_addr = (wr_sum >= (FW + 1)'(DEPTH)) ? HW'(wr_sum - (FW + 1)'(DEPTH))
                                                  : HW'(wr_sum);

    assign rd_tag = rd_tag_reg;
    assign fill   = fill_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[wr_addr] <= wr_tag;
        end
        if (ctrl.rd)
        begin
            rd_tag_reg <= mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else if (ctrl.push)
        begin
            fill_reg <= fill_reg + FW'(1);
        end
        else if (ctrl.pop)
        begin
            head_reg <= (head_reg == HW'(DEPTH - 1)) ? '0 : head_reg + HW'(1);
            fill_reg <= fill_reg - FW'(1);
        end
    end

endmodule

@@ src/typed_job_dispatch_queue.sv @@
// Typed job dispatch queue: top level. Instantiates the pending-job cell
// chain and the completion FIFO; depends on tjdq_pkg, tjdq_cell, tjdq_done_fifo.
//
// Every transaction on the input stream is one command (operation in tuser)
// and produces exactly one result transaction (status in tuser) carrying the
// claimed or retrieved tag, the assigned slot and the three occupancy counts
// as they stand after the command. Each command runs in an accept step and an
// execute step: the accept edge latches the command, registers every cell's
// match flag against the claim mask and reads the head of the completion
// FIFO; the execute step resolves the oldest match along the cell chain,
// compacts the chain, picks the lowest free slot and updates all state. The
// block takes one command at a time and accepts none while one executes. The
// result sits in an output register, so the next command is accepted while a
// result waits; if that result is still not taken when the next one is ready,
// the block holds in its execute state until the output register frees. Pending
// entries and completion FIFO entries have no reset; there is no clearing
// pass, the block is ready right after reset. Rejected commands (queue full,
// no match, no free slot, completion FIFO full) leave all state unchanged.
module typed_job_dispatch_queue
    import tjdq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int SLOT_COUNT  = DEF_SLOT_COUNT,
    parameter int DONE_DEPTH  = DEF_DONE_DEPTH,
    localparam int SW      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
    localparam int QCW     = $clog2(QUEUE_DEPTH + 1),
    localparam int ECW     = $clog2(SLOT_COUNT + 1),
    localparam int DCW     = $clog2(DONE_DEPTH + 1),
    localparam int IN_BITS = TAG_W + 2 * JTYPE_W + SW,
    localparam int IN_W    = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = TAG_W + SW + QCW + ECW + DCW,
    localparam int OUT_W   = ((OUT_BITS + 7) / 8) * 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // job_tag, job_type, claim_mask, exec_slot (lowest bit up), zero padded
    input  logic [IN_W-1:0]     s_axis_tdata,
    // operation
    input  logic [OP_W-1:0]     s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // out_tag, out_slot, queued_count, executing_count, completed_count
    // (lowest bit up), zero padded
    output logic [OUT_W-1:0]    m_axis_tdata,
    // status
    output logic [STATUS_W-1:0] m_axis_tuser
);

    // ------------------------------------------------------------------
    // Input unpacking
    // ------------------------------------------------------------------
    tag_t          in_tag;
    jtype_t        in_jtype;
    jtype_t        in_mask;
    logic [SW-1:0] in_slot;

    assign in_tag   = s_axis_tdata[0 +: TAG_W];
    assign in_jtype = s_axis_tdata[TAG_W +: JTYPE_W];
    assign in_mask  = s_axis_tdata[TAG_W + JTYPE_W +: JTYPE_W];
    assign in_slot  = s_axis_tdata[TAG_W + 2 * JTYPE_W +: SW];

    // ------------------------------------------------------------------
    // Control FSM
    // ------------------------------------------------------------------
    state_e state_reg;
    state_e state_next;
    logic   in_accept;
    logic   exec_go;
    logic   out_valid_reg;

    assign in_accept = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        exec_go       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // Finish only when the output register can take the result
                exec_go = !out_valid_reg || m_axis_tready;
                if (exec_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Command latch (payload, no reset)
    // ------------------------------------------------------------------
    op_e           op_reg;
    tag_t          tag_reg;
    jtype_t        jtype_reg;
    logic [SW-1:0] slot_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg    <= op_e'(s_axis_tuser);
            tag_reg   <= in_tag;
            jtype_reg <= in_jtype;
            slot_reg  <= in_slot;
        end
    end

    // ------------------------------------------------------------------
    // Occupancy state
    // ------------------------------------------------------------------
    logic [QCW-1:0]        q_fill_reg;
    logic [QCW-1:0]        q_fill_next;
    logic [SLOT_COUNT-1:0] busy_reg;
    logic [SLOT_COUNT-1:0] busy_next;
    logic [ECW-1:0]        running_reg;
    logic [ECW-1:0]        running_next;

    // ------------------------------------------------------------------
    // Pending-job cell chain
    // ------------------------------------------------------------------
    cell_ctrl_t cell_ctrl [QUEUE_DEPTH];
    tag_t       cell_tag  [QUEUE_DEPTH];
    jtype_t     cell_jtype[QUEUE_DEPTH];
    tag_t       cell_sel  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0] hit_chain;
    logic       enq_commit;
    logic       claim_commit;
    logic       any_hit;
    tag_t       hit_tag;

    assign hit_chain[0] = 1'b0;
    assign any_hit      = hit_chain[QUEUE_DEPTH];

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        tag_t   nbr_tag;
        jtype_t nbr_jtype;

        // The last cell has no neighbor; what it takes on compaction lies beyond the fill
        if (i < QUEUE_DEPTH - 1)
        begin : g_mid
            assign nbr_tag   = cell_tag[i + 1];
            assign nbr_jtype = cell_jtype[i + 1];
        end
        else
        begin : g_end
            assign nbr_tag   = cell_tag[i];
            assign nbr_jtype = cell_jtype[i];
        end

        assign cell_ctrl[i].capture = in_accept;
        assign cell_ctrl[i].load    = exec_go & enq_commit & (q_fill_reg == QCW'(i));
        assign cell_ctrl[i].shift   = exec_go & claim_commit;

        tjdq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl[i]),
            .entry_valid (q_fill_reg > QCW'(i)),
            .new_tag     (tag_reg),
            .new_jtype   (jtype_reg),
            .claim_mask  (in_mask),
            .nbr_tag     (nbr_tag),
            .nbr_jtype   (nbr_jtype),
            .hit_in      (hit_chain[i]),
            .hit_out     (hit_chain[i + 1]),
            .tag_out     (cell_tag[i]),
            .jtype_out   (cell_jtype[i]),
            .sel_tag     (cell_sel[i])
        );
    end

    // Only the first matching cell drives a nonzero tag
    always_comb
    begin
        hit_tag = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            hit_tag = hit_tag | cell_sel[i];
        end
    end

    // ------------------------------------------------------------------
    // Lowest free execution slot
    // ------------------------------------------------------------------
    logic          free_found;
    logic [SW-1:0] free_idx;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
    end

    // ------------------------------------------------------------------
    // Completion FIFO
    // ------------------------------------------------------------------
    fifo_ctrl_t     fifo_ctrl;
    tag_t           fifo_rd_tag;
    logic [DCW-1:0] d_fill;
    logic [DCW-1:0] d_fill_after;
    logic           fifo_push;
    logic           fifo_pop;
    logic           fifo_clear;

    assign fifo_ctrl.rd    = in_accept;
    assign fifo_ctrl.push  = exec_go & fifo_push;
    assign fifo_ctrl.pop   = exec_go & fifo_pop;
    assign fifo_ctrl.clear = exec_go & fifo_clear;

    tjdq_done_fifo #(
        .DEPTH (DONE_DEPTH)
    ) u_done_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (fifo_ctrl),
        .wr_tag (tag_reg),
        .rd_tag (fifo_rd_tag),
        .fill   (d_fill)
    );

    // ------------------------------------------------------------------
    // Command execution
    // ------------------------------------------------------------------
    status_e       status_next;
    tag_t          otag_next;
    logic [SW-1:0] oslot_next;

    always_comb
    begin
        status_next  = ST_DONE;
        otag_next    = '0;
        oslot_next   = '0;
        q_fill_next  = q_fill_reg;
        busy_next    = busy_reg;
        running_next = running_reg;
        enq_commit   = 1'b0;
        claim_commit = 1'b0;
        fifo_push    = 1'b0;
        fifo_pop     = 1'b0;
        fifo_clear   = 1'b0;
        case (op_reg)
            OP_ENQUEUE:
            begin
                if (q_fill_reg == QCW'(QUEUE_DEPTH))
                begin
                    status_next = ST_QUEUE_FULL;
                end
                else
                begin
                    enq_commit  = 1'b1;
                    q_fill_next = q_fill_reg + QCW'(1);
                end
            end
            OP_CLAIM:
            begin
                if (!any_hit)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!free_found)
                begin
                    status_next = ST_NO_SLOT;
                end
                else
                begin
                    claim_commit        = 1'b1;
                    otag_next           = hit_tag;
                    oslot_next          = free_idx;
                    q_fill_next         = q_fill_reg - QCW'(1);
                    busy_next[free_idx] = 1'b1;
                    running_next        = running_reg + ECW'(1);
                end
            end
            OP_COMPLETE:
            begin
                if (d_fill == DCW'(DONE_DEPTH))
                begin
                    status_next = ST_DONE_FULL;
                end
                else
                begin
                    fifo_push = 1'b1;
                    // A slot number past the table frees nothing
                    if ((SW + 1)'(slot_reg) < (SW + 1)'(SLOT_COUNT))
                    begin
                        busy_next[slot_reg] = 1'b0;
                    end
                    if (running_reg != '0)
                    begin
                        running_next = running_reg - ECW'(1);
                    end
                end
            end
            OP_RETRIEVE:
            begin
                if (d_fill == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    fifo_pop  = 1'b1;
                    otag_next = fifo_rd_tag;
                end
            end
            OP_CLEAR_PEND:
            begin
                q_fill_next = '0;
            end
            OP_CLEAR_DONE:
            begin
                fifo_clear = 1'b1;
            end
            default:
            begin
                // Unused codes: no state change, done status
            end
        endcase
    end

    always_comb
    begin
        if (fifo_clear)
        begin
            d_fill_after = '0;
        end
        else if (fifo_push)
        begin
            d_fill_after = d_fill + DCW'(1);
        end
        else if (fifo_pop)
        begin
            d_fill_after = d_fill - DCW'(1);
        end
        else
        begin
            d_fill_after = d_fill;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_fill_reg  <= '0;
            busy_reg    <= '0;
            running_reg <= '0;
        end
        else if (exec_go)
        begin
            q_fill_reg  <= q_fill_next;
            busy_reg    <= busy_next;
            running_reg <= running_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    status_e        status_reg;
    tag_t           otag_reg;
    logic [SW-1:0]  oslot_reg;
    logic [QCW-1:0] qcount_reg;
    logic [ECW-1:0] ecount_reg;
    logic [DCW-1:0] dcount_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            status_reg <= status_next;
            otag_reg   <= otag_next;
            oslot_reg  <= oslot_next;
            qcount_reg <= q_fill_next;
            ecount_reg <= running_next;
            dcount_reg <= d_fill_after;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = OUT_W'({dcount_reg, ecount_reg, qcount_reg, oslot_reg, otag_reg});

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_fill_reg <= QCW'(QUEUE_DEPTH))
        else $error("pending fill exceeds queue depth");

    a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
        d_fill <= DCW'(DONE_DEPTH))
        else $error("completion fill exceeds FIFO depth");

    a_running_le_busy: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg <= $countones(busy_reg))
        else $error("running count exceeds busy slots");

    a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_EXEC))
        else $error("result raised without an executed command");

endmodule
